// File: design/pad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_pkg: shared types for the parity alternating deque
// Item and result payloads, status codes and controller states.
// ----------------------------------------------------------------------------
package pad_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int HELD_W        = 7;

    typedef enum logic
    {
        OP_STORE    = 1'b0,
        OP_RETRIEVE = 1'b1
    } pad_op_t;

    typedef enum logic [1:0]
    {
        ST_STORED    = 2'd0,
        ST_RETRIEVED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } pad_status_t;

    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_DONE = 1'b1
    } pad_state_t;

    typedef struct packed
    {
        pad_op_t                   operation;
        logic signed [WORD_W-1:0]  value;
    } pad_in_t;

    typedef struct packed
    {
        logic signed [WORD_W-1:0]  read_value;
        pad_status_t               status;
        logic [HELD_W-1:0]         held_count;
        logic                      took_newest;
    } pad_out_t;

    typedef struct packed
    {
        logic step;
    } pad_cmd_t;

endpackage

// File: design/pad_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_ctrl: handshake controller
// Accepts an item, issues one step to the datapath, holds the result valid
// until taken. A new item is taken in the cycle the result leaves.
// ----------------------------------------------------------------------------
module pad_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    output logic              result_valid,
    input  logic              result_stall,
    output pad_pkg::pad_cmd_t cmd
);
    import pad_pkg::*;

    pad_state_t state_reg;
    pad_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        item_stall   = (state_reg == S_DONE) && result_stall;
        result_valid = (state_reg == S_DONE);
        cmd.step     = item_valid && !item_stall;
        state_next   = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.step)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (cmd.step)
                begin
                    state_next = S_DONE;
                end
                else if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/pad_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_dp: ring buffer datapath
// Word memory, oldest and next-newest pointers, word count and result
// registers. Retrieve takes the newest word on odd count, else the oldest.
// ----------------------------------------------------------------------------
module pad_dp
#(
    parameter int DEPTH = pad_pkg::DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pad_pkg::pad_cmd_t cmd,
    input  pad_pkg::pad_in_t  item,
    output pad_pkg::pad_out_t result
);
    import pad_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > HELD_W) ? CW : HELD_W;
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic signed [WORD_W-1:0] mem [DEPTH];

    logic [PW-1:0]            oldest_reg;
    logic [PW-1:0]            oldest_next;
    logic [PW-1:0]            newest_next_reg;
    logic [PW-1:0]            newest_next_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    pad_status_t              status_reg;
    pad_status_t              status_next;
    logic                     took_reg;
    logic                     took_next;
    logic signed [WORD_W-1:0] rd_data_reg;

    logic [PW-1:0]            rd_addr;
    logic                     wr_en;
    logic [EW-1:0]            count_ext;

    always_comb
    begin
        oldest_next      = oldest_reg;
        newest_next_next = newest_next_reg;
        count_next       = count_reg;
        status_next      = status_reg;
        took_next        = took_reg;
        rd_addr          = oldest_reg;
        wr_en            = 1'b0;
        if (cmd.step)
        begin
            took_next = 1'b0;
            case (item.operation)
                OP_STORE:
                begin
                    if (count_reg == FULL_CNT)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en            = 1'b1;
                        newest_next_next = (newest_next_reg == LAST_IDX) ?
                                           '0 : newest_next_reg + 1'b1;
                        count_next       = count_reg + 1'b1;
                        status_next      = ST_STORED;
                    end
                end
                OP_RETRIEVE:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        if (count_reg[0])
                        begin
                            newest_next_next = (newest_next_reg == '0) ?
                                               LAST_IDX : newest_next_reg - 1'b1;
                            rd_addr          = newest_next_next;
                            took_next        = 1'b1;
                        end
                        else
                        begin
                            rd_addr     = oldest_reg;
                            oldest_next = (oldest_reg == LAST_IDX) ?
                                          '0 : oldest_reg + 1'b1;
                        end
                        count_next  = count_reg - 1'b1;
                        status_next = ST_RETRIEVED;
                    end
                end
                default:
                begin
                    status_next = ST_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg      <= '0;
            newest_next_reg <= '0;
            count_reg       <= '0;
        end
        else
        begin
            oldest_reg      <= oldest_next;
            newest_next_reg <= newest_next_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        took_reg   <= took_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[newest_next_reg] <= item.value;
        end
        if (cmd.step)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign count_ext = EW'(count_reg);

    always_comb
    begin
        result.read_value  = (status_reg == ST_RETRIEVED) ? rd_data_reg : '0;
        result.status      = status_reg;
        result.held_count  = count_ext[HELD_W-1:0];
        result.took_newest = took_reg;
    end

endmodule

// File: design/parity_alternating_deque_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parity_alternating_deque_top: mixed stack/queue of signed 32-bit words
// Ring buffer of DEPTH words; retrieve takes newest on odd count, oldest on
// even count.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall/item): operation 0 stores value at
//   the newest end, 1 retrieves one word. Store into a full buffer is
//   dropped with status full; retrieve from empty gives 0 with status empty.
//   result channel (result_valid/result_stall/result): one result per item,
//   carrying the word, status, count held after the step and a newest flag.
//   Latency: the result is valid the cycle after the item is accepted.
//   Throughput: one item per cycle while results are taken; the memory read
//   is registered at the accept edge and the result register is freed in the
//   cycle it is taken, so a new item is taken in that same cycle.
//   A stalled result holds; item_stall is high while a result waits.
//   Reset empties the buffer (pointers and count cleared) and drops any
//   pending result. No clearing pass: memory contents are not reset.
// ----------------------------------------------------------------------------
module parity_alternating_deque_top
#(
    parameter int DEPTH = pad_pkg::DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  pad_pkg::pad_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output pad_pkg::pad_out_t result
);
    import pad_pkg::*;

    pad_cmd_t cmd;

    pad_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    pad_dp #(.DEPTH(DEPTH)) u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule

// File: design/pad_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_chk: port checker for the parity alternating deque
// Watches the top level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module pad_chk
#(
    parameter int DEPTH = pad_pkg::DEPTH_DEFAULT
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input pad_pkg::pad_out_t result
);
    import pad_pkg::*;

    localparam logic [HELD_W-1:0] FULL_HELD = HELD_W'(DEPTH);

    logic item_take;
    assign item_take = item_valid && !item_stall;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> result_valid)
        else $error("no result the cycle after an item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_EMPTY |->
            result.held_count == '0 && result.read_value == '0)
        else $error("empty result with words held");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_FULL |-> result.held_count == FULL_HELD)
        else $error("full result with wrong count");

    a_newest: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.took_newest |->
            result.status == ST_RETRIEVED && !result.held_count[0])
        else $error("newest taken from even count");

endmodule

bind parity_alternating_deque_top pad_chk #(.DEPTH(DEPTH)) u_pad_chk (.*);

// File: bench/parity_alternating_deque_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parity_alternating_deque_top_test: self-checking bench for the deque
// Drives store/retrieve items with random gaps and result stalls, mirrors
// the ring buffer to predict each result, and checks every result in order.
// ----------------------------------------------------------------------------
module parity_alternating_deque_top_test;

    import pad_pkg::*;

    localparam int RING_DEPTH  = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 750;

    class deque_mirror;
        logic signed [WORD_W-1:0] words[RING_DEPTH];
        int                       head;
        int                       tail;
        int                       held;
        pad_out_t                 due_results[$];
        int                       mismatches;

        function new();
            head       = 0;
            tail       = 0;
            held       = 0;
            mismatches = 0;
        endfunction

        function void note_item(pad_in_t it);
            pad_out_t want;
            want = '0;
            if (it.operation == OP_STORE)
            begin
                if (held >= RING_DEPTH)
                begin
                    want.status = ST_FULL;
                end
                else
                begin
                    words[tail] = it.value;
                    tail        = (tail == RING_DEPTH - 1) ? 0 : tail + 1;
                    held++;
                    want.status = ST_STORED;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    want.status = ST_EMPTY;
                end
                else
                begin
                    if (held % 2 == 1)
                    begin
                        tail             = (tail == 0) ? RING_DEPTH - 1 : tail - 1;
                        want.read_value  = words[tail];
                        want.took_newest = 1'b1;
                    end
                    else
                    begin
                        want.read_value = words[head];
                        head            = (head == RING_DEPTH - 1) ? 0 : head + 1;
                    end
                    held--;
                    want.status = ST_RETRIEVED;
                end
            end
            want.held_count = HELD_W'(held);
            due_results.push_back(want);
        endfunction

        function void check_result(pad_out_t got);
            pad_out_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: value %0d status %0d held %0d newest %0b",
                             got.read_value, got.status, got.held_count, got.took_newest);
                end
                return;
            end
            want = due_results.pop_front();
            if (got.read_value !== want.read_value || got.status !== want.status ||
                got.held_count !== want.held_count || got.took_newest !== want.took_newest)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch: exp value %0d status %0d held %0d newest %0b,",
                             want.read_value, want.status, want.held_count,
                             want.took_newest,
                             " got value %0d status %0d held %0d newest %0b",
                             got.read_value, got.status,
                             got.held_count, got.took_newest);
                end
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_stall;
    pad_in_t  item         = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    pad_out_t result;

    deque_mirror mirror       = new();
    bit          sender_idle  = 1'b1;
    bit          reader_idle  = 1'b1;
    int          reader_wait  = 0;

    parity_alternating_deque_top
    #(
        .DEPTH(RING_DEPTH)
    )
    u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #2 clk = ~clk;

    // result side: check on each take, then draw the next wait
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                mirror.check_result(result);
                reader_wait = reader_idle ? $urandom_range(0, 5) : 0;
            end
            if ($urandom_range(0, 63) == 0)
            begin
                reader_idle = !reader_idle;
            end
            result_stall <= (reader_wait > 0);
            if (reader_wait > 0)
            begin
                reader_wait--;
            end
        end
    end

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input pad_op_t op, input logic signed [WORD_W-1:0] word);
        pad_in_t nxt;
        int      gap;
        nxt.operation = op;
        nxt.value     = word;
        gap = sender_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= nxt;
        do
            @(posedge clk);
        while (item_stall);
        mirror.note_item(nxt);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (mirror.outstanding() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int seg_len;
        int store_pct;
        int sent;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty retrieve, extremes, both parities
        send_item(OP_RETRIEVE, pick_word());
        send_item(OP_STORE, 32'sh7FFF_FFFF);
        send_item(OP_STORE, 32'sh8000_0000);
        send_item(OP_STORE, '1);
        send_item(OP_STORE, '0);
        send_item(OP_STORE, 32'sh0000_0001);
        send_item(OP_RETRIEVE, 32'sh7FFF_FFFF);
        send_item(OP_RETRIEVE, '0);
        send_item(OP_RETRIEVE, '1);
        send_item(OP_RETRIEVE, 32'sh8000_0000);
        send_item(OP_RETRIEVE, pick_word());
        send_item(OP_RETRIEVE, pick_word());
        send_item(OP_STORE, 32'sh5555_AAAA);
        send_item(OP_RETRIEVE, pick_word());
        send_item(OP_RETRIEVE, pick_word());
        wait_drained();

        // fill past full, then drain past empty
        for (int i = 0; i < RING_DEPTH + 6; i++)
        begin
            send_item(OP_STORE, pick_word());
        end
        for (int i = 0; i < RING_DEPTH + 6; i++)
        begin
            send_item(OP_RETRIEVE, pick_word());
        end
        sent = 2 * (RING_DEPTH + 6);

        while (sent < RANDOM_ITEMS)
        begin
            seg_len     = $urandom_range(20, 80);
            sender_idle = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 4))
                0:       store_pct = 10;
                1:       store_pct = 95;
                2:       store_pct = 75;
                default: store_pct = 50;
            endcase
            for (int i = 0; i < seg_len; i++)
            begin
                if ($urandom_range(1, 100) <= store_pct)
                begin
                    send_item(OP_STORE, pick_word());
                end
                else
                begin
                    send_item(OP_RETRIEVE, pick_word());
                end
            end
            sent += seg_len;
            if ($urandom_range(0, 3) == 0)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mirror.mismatches == 0)
        begin
            $display("parity_alternating_deque_top_test: clean");
        end
        else
        begin
            $display("parity_alternating_deque_top_test: errors");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("parity_alternating_deque_top_test: errors");
        $finish;
    end

endmodule
